>>> design/mfl_pkg.sv
// ----------------------------------------------------------------------------
// mfl_pkg
// Shared constants, types and the letter-slot decode for the most frequent
// letter block.
// ----------------------------------------------------------------------------
package mfl_pkg;

    localparam longint unsigned MAX_LEN_DEF = 64'd65535;
    localparam int NUM_LETTERS = 52;
    localparam int SLOT_W = 6;
    localparam int CHAR_W = 8;
    localparam int LOWER_BASE = 26;

    localparam logic [CHAR_W-1:0] CHAR_UPPER_A = 8'h41;
    localparam logic [CHAR_W-1:0] CHAR_UPPER_Z = 8'h5A;
    localparam logic [CHAR_W-1:0] CHAR_LOWER_A = 8'h61;
    localparam logic [CHAR_W-1:0] CHAR_LOWER_Z = 8'h7A;

    typedef logic [SLOT_W-1:0] slot_t;

    typedef struct packed {
        logic  letter;
        slot_t idx;
    } slot_info_t;

    // Write/clear request from the tally stage to the count store.
    typedef struct packed {
        logic  wr_en;
        slot_t wr_slot;
        logic  clear;
    } mfl_wr_ctrl_t;

    // A-Z -> 0..25, a-z -> 26..51, anything else is not a letter.
    function automatic slot_info_t slot_of(input logic [CHAR_W-1:0] c);
        slot_info_t r;
        logic [CHAR_W-1:0] diff;
        r    = '0;
        diff = '0;
        if (c >= CHAR_UPPER_A && c <= CHAR_UPPER_Z) begin
            diff     = c - CHAR_UPPER_A;
            r.letter = 1'b1;
            r.idx    = diff[SLOT_W-1:0];
        end else if (c >= CHAR_LOWER_A && c <= CHAR_LOWER_Z) begin
            diff     = c - CHAR_LOWER_A + CHAR_W'(LOWER_BASE);
            r.letter = 1'b1;
            r.idx    = diff[SLOT_W-1:0];
        end
        return r;
    endfunction

endpackage

>>> design/mfl_count_mem.sv
// ----------------------------------------------------------------------------
// mfl_count_mem
// Per-letter store of count and first position. One write and one registered
// read per cycle, with bypass of a same-cycle write and per-entry valid bits
// so a clear takes effect at once.
// ----------------------------------------------------------------------------
module mfl_count_mem #(
    parameter int CNT_W = 16
) (
    input  logic                 aclk,
    input  logic                 aresetn,
    input  logic                 rd_en,
    input  mfl_pkg::slot_t       rd_slot,
    input  mfl_pkg::mfl_wr_ctrl_t wr_ctrl,
    input  logic [CNT_W-1:0]     wr_count,
    input  logic [CNT_W-1:0]     wr_first,
    output logic                 rd_hit,
    output logic [CNT_W-1:0]     rd_count,
    output logic [CNT_W-1:0]     rd_first
);
    import mfl_pkg::*;

    logic [2*CNT_W-1:0]     mem [NUM_LETTERS];
    logic [NUM_LETTERS-1:0] valid_reg;
    logic [2*CNT_W-1:0]     rd_data_reg;
    logic                   rd_hit_reg;
    logic                   bypass;

    assign bypass = wr_ctrl.wr_en && (wr_ctrl.wr_slot == rd_slot);

    always_ff @(posedge aclk) begin
        if (wr_ctrl.wr_en) begin
            mem[wr_ctrl.wr_slot] <= {wr_first, wr_count};
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= '0;
        end else if (wr_ctrl.clear) begin
            valid_reg <= '0;
        end else if (wr_ctrl.wr_en) begin
            valid_reg[wr_ctrl.wr_slot] <= 1'b1;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            rd_hit_reg <= 1'b0;
        end else if (rd_en) begin
            // a clear in the same cycle empties the store for this read
            rd_hit_reg <= !wr_ctrl.clear && (bypass || valid_reg[rd_slot]);
        end
    end

    always_ff @(posedge aclk) begin
        if (rd_en) begin
            rd_data_reg <= bypass ? {wr_first, wr_count} : mem[rd_slot];
        end
    end

    assign rd_hit   = rd_hit_reg;
    assign rd_count = rd_data_reg[CNT_W-1:0];
    assign rd_first = rd_data_reg[2*CNT_W-1:CNT_W];

endmodule

>>> design/mfl_tally.sv
// ----------------------------------------------------------------------------
// mfl_tally
// Item stage: takes the byte with its looked-up count, bumps the count,
// tracks position, leader and saturation, and emits the result on the
// last byte of a string.
// ----------------------------------------------------------------------------
module mfl_tally #(
    parameter longint unsigned MAX_LEN = mfl_pkg::MAX_LEN_DEF,
    parameter int              CNT_W   = 16
) (
    input  logic                        aclk,
    input  logic                        aresetn,
    input  logic                        advance,
    input  logic                        in_valid,
    input  logic [mfl_pkg::CHAR_W-1:0]  in_char,
    input  logic                        in_last,
    input  logic                        rd_hit,
    input  logic [CNT_W-1:0]            rd_count,
    input  logic [CNT_W-1:0]            rd_first,
    output mfl_pkg::mfl_wr_ctrl_t       wr_ctrl,
    output logic [CNT_W-1:0]            wr_count,
    output logic [CNT_W-1:0]            wr_first,
    output logic                        hold_last,
    output logic                        res_valid,
    output logic [mfl_pkg::CHAR_W-1:0]  res_letter,
    output logic                        res_saturated
);
    import mfl_pkg::*;

    localparam logic [CNT_W-1:0] MAX_CNT = CNT_W'(MAX_LEN);

    logic                 st_valid_reg;
    logic [CHAR_W-1:0]    char_reg;
    logic                 last_reg;

    logic [CNT_W-1:0]     pos_reg, pos_next;
    logic [CHAR_W-1:0]    best_letter_reg, best_letter_next;
    logic [CNT_W-1:0]     best_count_reg, best_count_next;
    logic [CNT_W-1:0]     best_first_reg, best_first_next;
    logic [CHAR_W-1:0]    opening_reg, opening_next;
    logic                 overflow_reg, overflow_next;

    slot_info_t           info;
    logic                 fire;
    logic                 pos_sat;
    logic [CNT_W-1:0]     cnt_old;
    logic [CNT_W-1:0]     cnt_new;
    logic [CNT_W-1:0]     first_pos;
    logic                 take;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            st_valid_reg <= 1'b0;
        end else if (advance) begin
            st_valid_reg <= in_valid;
        end
    end

    always_ff @(posedge aclk) begin
        if (advance) begin
            char_reg <= in_char;
            last_reg <= in_last;
        end
    end

    assign fire    = advance && st_valid_reg;
    assign info    = slot_of(char_reg);
    assign pos_sat = (pos_reg == MAX_CNT);
    assign cnt_old = rd_hit ? rd_count : '0;
    assign first_pos = (cnt_old == '0) ? pos_reg : rd_first;
    assign cnt_new = (cnt_old < MAX_CNT) ? cnt_old + 1'b1 : cnt_old;

    assign take = info.letter && ((best_count_reg == '0) || (char_reg == best_letter_reg) ||
                  (cnt_new > best_count_reg) ||
                  ((cnt_new == best_count_reg) && (first_pos < best_first_reg)));

    always_comb begin
        pos_next         = pos_sat ? pos_reg : pos_reg + 1'b1;
        opening_next     = (pos_reg == '0) ? char_reg : opening_reg;
        overflow_next    = overflow_reg || pos_sat || (info.letter && (cnt_new == MAX_CNT));
        best_letter_next = take ? char_reg  : best_letter_reg;
        best_count_next  = take ? cnt_new   : best_count_reg;
        best_first_next  = take ? first_pos : best_first_reg;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            pos_reg         <= '0;
            best_letter_reg <= '0;
            best_count_reg  <= '0;
            best_first_reg  <= '0;
            opening_reg     <= '0;
            overflow_reg    <= 1'b0;
        end else if (fire) begin
            if (last_reg) begin
                pos_reg         <= '0;
                best_letter_reg <= '0;
                best_count_reg  <= '0;
                best_first_reg  <= '0;
                opening_reg     <= '0;
                overflow_reg    <= 1'b0;
            end else begin
                pos_reg         <= pos_next;
                best_letter_reg <= best_letter_next;
                best_count_reg  <= best_count_next;
                best_first_reg  <= best_first_next;
                opening_reg     <= opening_next;
                overflow_reg    <= overflow_next;
            end
        end
    end

    always_comb begin
        wr_ctrl.wr_en   = fire && info.letter;
        wr_ctrl.wr_slot = info.idx;
        wr_ctrl.clear   = fire && last_reg;
    end

    assign wr_count = cnt_new;
    assign wr_first = first_pos;

    assign hold_last     = st_valid_reg && last_reg;
    assign res_valid     = fire && last_reg;
    assign res_letter    = (best_count_next != '0) ? best_letter_next : opening_next;
    assign res_saturated = overflow_next;

endmodule

>>> design/most_frequent_letter.sv
// ----------------------------------------------------------------------------
// most_frequent_letter
// Streams a byte string and returns its most frequent letter.
// ----------------------------------------------------------------------------
// Usage:
//   s_* channel: one string byte per request, s_tlast on the final byte.
//   m_* channel: one result per string, sent after its final byte.
//   Letters A-Z and a-z are counted separately; ties go to the letter seen
//   first. A string with no letter returns its first byte. m_tuser is set
//   when a letter count or the byte position reached MAX_LEN.
// Timing:
//   One byte per cycle sustained while no final byte waits for the output
//   register. The count store is read on the edge that takes the final byte;
//   the item stage then does the count update and leader compare and loads
//   the output register once that register is free.
//   The store read is bypassed from the write of the previous byte, so the
//   same letter may arrive on consecutive cycles.
// Reset and stall:
//   aresetn (synchronous) clears counts, leader, position and the output.
//   While a result waits on m_tready, bytes keep flowing; only the final
//   byte of the next string holds, and the input with it, until the output register is free.
// ----------------------------------------------------------------------------
module most_frequent_letter #(
    parameter longint unsigned MAX_LEN = mfl_pkg::MAX_LEN_DEF
) (
    input  logic                       aclk,
    input  logic                       aresetn,
    input  logic                       s_tvalid,
    output logic                       s_tready,
    input  logic [mfl_pkg::CHAR_W-1:0] s_tdata,   // [7:0] char_code
    input  logic                       s_tlast,   // last_byte
    output logic                       m_tvalid,
    input  logic                       m_tready,
    output logic [mfl_pkg::CHAR_W-1:0] m_tdata,   // [7:0] most_frequent
    output logic                       m_tuser    // [0] saturated
);
    import mfl_pkg::*;

    localparam int CNT_W = $clog2(MAX_LEN + 64'd1);

    logic              advance;
    logic              accept;
    slot_info_t        in_info;
    mfl_wr_ctrl_t      wr_ctrl;
    logic [CNT_W-1:0]  wr_count;
    logic [CNT_W-1:0]  wr_first;
    logic              rd_hit;
    logic [CNT_W-1:0]  rd_count;
    logic [CNT_W-1:0]  rd_first;
    logic              hold_last;
    logic              res_valid;
    logic [CHAR_W-1:0] res_letter;
    logic              res_saturated;

    logic              m_valid_reg;
    logic [CHAR_W-1:0] m_data_reg;
    logic              m_user_reg;

    // only a final byte in the item stage waits for the output register
    assign advance  = !(hold_last && m_valid_reg && !m_tready);
    assign s_tready = advance;
    assign accept   = s_tvalid && advance;
    assign in_info  = slot_of(s_tdata);

    mfl_count_mem #(
        .CNT_W (CNT_W)
    ) u_mem (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .rd_en    (accept && in_info.letter),
        .rd_slot  (in_info.idx),
        .wr_ctrl  (wr_ctrl),
        .wr_count (wr_count),
        .wr_first (wr_first),
        .rd_hit   (rd_hit),
        .rd_count (rd_count),
        .rd_first (rd_first)
    );

    mfl_tally #(
        .MAX_LEN (MAX_LEN),
        .CNT_W   (CNT_W)
    ) u_tally (
        .aclk          (aclk),
        .aresetn       (aresetn),
        .advance       (advance),
        .in_valid      (accept),
        .in_char       (s_tdata),
        .in_last       (s_tlast),
        .rd_hit        (rd_hit),
        .rd_count      (rd_count),
        .rd_first      (rd_first),
        .wr_ctrl       (wr_ctrl),
        .wr_count      (wr_count),
        .wr_first      (wr_first),
        .hold_last     (hold_last),
        .res_valid     (res_valid),
        .res_letter    (res_letter),
        .res_saturated (res_saturated)
    );

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg <= 1'b0;
        end else if (res_valid) begin
            m_valid_reg <= 1'b1;
        end else if (m_tready) begin
            m_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (res_valid) begin
            m_data_reg <= res_letter;
            m_user_reg <= res_saturated;
        end
    end

    assign m_tvalid = m_valid_reg;
    assign m_tdata  = m_data_reg;
    assign m_tuser  = m_user_reg;

endmodule
